FILE: design/sabf_pkg.sv
package sabf_pkg;

  localparam int unsigned ReadingW   = 16;
  localparam int unsigned DigitCount = 5;
  localparam int unsigned BcdW       = 4 * DigitCount;
  localparam int unsigned AddrW      = 16;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned FrameLen   = 22;
  localparam int unsigned PosW       = $clog2(FrameLen);
  localparam int unsigned QueueDepthDef = 2;

  localparam logic [AddrW-1:0] DestReset   = 16'd51;
  localparam logic [AddrW-1:0] SourceReset = 16'd1;
  localparam logic [ByteW-1:0] PayloadLen  = 8'd17;

  localparam logic [ByteW-1:0] ChR     = 8'h52;
  localparam logic [ByteW-1:0] ChOne   = 8'h31;
  localparam logic [ByteW-1:0] ChTwo   = 8'h32;
  localparam logic [ByteW-1:0] ChColon = 8'h3a;
  localparam logic [ByteW-1:0] ChComma = 8'h2c;
  localparam logic [ByteW-1:0] ChZero  = 8'h30;

  // Byte positions within the frame
  localparam logic [PosW-1:0] PosDestLo   = 5'd0;
  localparam logic [PosW-1:0] PosDestHi   = 5'd1;
  localparam logic [PosW-1:0] PosSrcLo    = 5'd2;
  localparam logic [PosW-1:0] PosSrcHi    = 5'd3;
  localparam logic [PosW-1:0] PosLen      = 5'd4;
  localparam logic [PosW-1:0] PosTagR1    = 5'd5;
  localparam logic [PosW-1:0] PosTag1     = 5'd6;
  localparam logic [PosW-1:0] PosColon1   = 5'd7;
  localparam logic [PosW-1:0] PosDigOne   = 5'd8;
  localparam logic [PosW-1:0] PosDigOneE  = 5'd12;
  localparam logic [PosW-1:0] PosComma    = 5'd13;
  localparam logic [PosW-1:0] PosTagR2    = 5'd14;
  localparam logic [PosW-1:0] PosTag2     = 5'd15;
  localparam logic [PosW-1:0] PosColon2   = 5'd16;
  localparam logic [PosW-1:0] PosDigTwo   = 5'd17;
  localparam logic [PosW-1:0] PosLast     = 5'd21;

  // Register indexes on the APB port
  localparam logic RegDest   = 1'b0;
  localparam logic RegSource = 1'b1;

  typedef struct packed {
    logic [BcdW-1:0] bcd_one;
    logic [BcdW-1:0] bcd_two;
  } sabf_entry_t;

endpackage

FILE: design/sabf_front.sv
module sabf_front
  import sabf_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [ReadingW-1:0] reading_one_i,
  input  logic [ReadingW-1:0] reading_two_i,
  input  logic                q_full_i,
  output logic                q_push_o,
  output sabf_entry_t         q_data_o
);

  typedef enum logic [1:0] {FeIdle, FeConv, FeHold} fe_state_e;

  localparam int unsigned CntW = $clog2(ReadingW);
  localparam logic [CntW-1:0] CntLast = CntW'(ReadingW - 1);

  fe_state_e       state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [ReadingW-1:0] bin_one_q, bin_two_q;
  logic [BcdW-1:0]     bcd_one_q, bcd_two_q;
  logic            accept;

  // One double-dabble step: add three to every digit of five or more, then shift.
  function automatic logic [BcdW-1:0] dd_step(input logic [BcdW-1:0] bcd, input logic msb);
    logic [BcdW-1:0] adj;
    adj = bcd;
    for (int d = 0; d < DigitCount; d++) begin
      if (adj[4*d +: 4] >= 4'd5) begin
        adj[4*d +: 4] = adj[4*d +: 4] + 4'd3;
      end
    end
    return {adj[BcdW-2:0], msb};
  endfunction

  assign q_push_o   = (state_q == FeHold) && !q_full_i;
  assign in_stall_o = !((state_q == FeIdle) || q_push_o);
  assign accept     = in_valid_i && !in_stall_o;
  assign q_data_o   = '{bcd_one: bcd_one_q, bcd_two: bcd_two_q};

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      FeIdle: begin
        if (accept) begin
          state_d = FeConv;
          cnt_d   = '0;
        end
      end
      FeConv: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntLast) begin
          state_d = FeHold;
        end
      end
      FeHold: begin
        if (accept) begin
          state_d = FeConv;
          cnt_d   = '0;
        end else if (q_push_o) begin
          state_d = FeIdle;
        end
      end
      default: state_d = FeIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FeIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      bin_one_q <= reading_one_i;
      bin_two_q <= reading_two_i;
      bcd_one_q <= '0;
      bcd_two_q <= '0;
    end else if (state_q == FeConv) begin
      bin_one_q <= {bin_one_q[ReadingW-2:0], 1'b0};
      bin_two_q <= {bin_two_q[ReadingW-2:0], 1'b0};
      bcd_one_q <= dd_step(bcd_one_q, bin_one_q[ReadingW-1]);
      bcd_two_q <= dd_step(bcd_two_q, bin_two_q[ReadingW-1]);
    end
  end

endmodule

FILE: design/sabf_queue.sv
module sabf_queue
  import sabf_pkg::*;
#(
  parameter int unsigned QueueDepth = QueueDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  sabf_entry_t push_data_i,
  output logic        full_o,
  input  logic        pop_i,
  output sabf_entry_t head_o,
  output logic        empty_o
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(QueueDepth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(QueueDepth);

  sabf_entry_t     mem_q [QueueDepth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntFull);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == PtrLast) ? '0 : wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == PtrLast) ? '0 : rptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

endmodule

FILE: design/sabf_back.sv
module sabf_back
  import sabf_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [AddrW-1:0] dest_address_i,
  input  logic [AddrW-1:0] source_address_i,
  input  sabf_entry_t      head_i,
  input  logic             empty_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [ByteW-1:0] frame_byte_o,
  output logic             last_byte_o
);

  logic [PosW-1:0]  pos_q;
  logic             out_valid_q;
  logic [ByteW-1:0] byte_q, byte_d;
  logic             last_q;
  logic             load, fire, at_last;
  logic [PosW-1:0]  dig_off;

  function automatic logic [ByteW-1:0] to_ascii(input logic [BcdW-1:0] bcd,
                                                input logic [PosW-1:0] k);
    logic [2:0] sel;
    logic [3:0] dig;
    sel = k[2:0];
    dig = bcd[BcdW-1-4*sel -: 4];
    return ChZero | {4'b0000, dig};
  endfunction

  assign load    = !out_valid_q || !out_stall_i;
  assign fire    = load && !empty_i;
  assign at_last = (pos_q == PosLast);
  assign pop_o   = fire && at_last;

  always_comb begin
    dig_off = '0;
    case (pos_q) inside
      PosDestLo: byte_d = dest_address_i[ByteW-1:0];
      PosDestHi: byte_d = dest_address_i[AddrW-1:ByteW];
      PosSrcLo:  byte_d = source_address_i[ByteW-1:0];
      PosSrcHi:  byte_d = source_address_i[AddrW-1:ByteW];
      PosLen:    byte_d = PayloadLen;
      PosTagR1:  byte_d = ChR;
      PosTag1:   byte_d = ChOne;
      PosColon1: byte_d = ChColon;
      [PosDigOne:PosDigOneE]: begin
        dig_off = pos_q - PosDigOne;
        byte_d  = to_ascii(head_i.bcd_one, dig_off);
      end
      PosComma:  byte_d = ChComma;
      PosTagR2:  byte_d = ChR;
      PosTag2:   byte_d = ChTwo;
      PosColon2: byte_d = ChColon;
      [PosDigTwo:PosLast]: begin
        dig_off = pos_q - PosDigTwo;
        byte_d  = to_ascii(head_i.bcd_two, dig_off);
      end
      default:   byte_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (fire) begin
      pos_q       <= at_last ? '0 : pos_q + 1'b1;
      out_valid_q <= 1'b1;
    end else if (load) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      byte_q <= byte_d;
      last_q <= at_last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign frame_byte_o = byte_q;
  assign last_byte_o  = last_q;

endmodule

FILE: design/sensor_ascii_frame_builder.sv
// Frame builder: each accepted pair of 16-bit readings gives a 22-byte frame, one byte per
// output transaction - destination and source address (little-endian), length 17, then
// "R1:ddddd,R2:ddddd" with both readings as five zero-padded decimal digits; last_byte_o
// marks the final byte. The byte sequencer sends one byte per cycle while the receiver
// does not stall and a converted pair is queued. The input side converts both readings to
// decimal one binary bit a cycle and hands them over through a short queue, so conversion
// of the next pair overlaps with sending the current frame. Addresses are set over the APB
// port (dest at 0x0, source at 0x4) and should only be changed while no frame is in flight.
module sensor_ascii_frame_builder
  import sabf_pkg::*;
#(
  parameter int unsigned QueueDepth = QueueDepthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [ReadingW-1:0] reading_one_i,
  input  logic [ReadingW-1:0] reading_two_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [ByteW-1:0]    frame_byte_o,
  output logic                last_byte_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  logic [AddrW-1:0] dest_q, source_q;
  logic             reg_sel;
  logic             q_full, q_empty, q_push, q_pop;
  sabf_entry_t      q_wdata, q_head;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dest_q   <= DestReset;
      source_q <= SourceReset;
    end else if (psel && penable && pwrite) begin
      case (reg_sel)
        RegDest:   dest_q   <= pwdata[AddrW-1:0];
        RegSource: source_q <= pwdata[AddrW-1:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      RegDest:   prdata = {16'h0000, dest_q};
      RegSource: prdata = {16'h0000, source_q};
      default:   prdata = '0;
    endcase
  end

  sabf_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .reading_one_i (reading_one_i),
    .reading_two_i (reading_two_i),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_data_o      (q_wdata)
  );

  sabf_queue #(
    .QueueDepth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_wdata),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .head_o      (q_head),
    .empty_o     (q_empty)
  );

  sabf_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .dest_address_i   (dest_q),
    .source_address_i (source_q),
    .head_i           (q_head),
    .empty_i          (q_empty),
    .pop_o            (q_pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .frame_byte_o     (frame_byte_o),
    .last_byte_o      (last_byte_o)
  );

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps

module tb;
  import sabf_pkg::*;

  localparam int unsigned TextW     = 8 * 17;
  localparam logic [7:0]  LenByte   = 8'd17;
  localparam int unsigned QuietMax  = 2000;
  localparam int unsigned HoldLen   = 300;
  localparam int unsigned TailWait  = 40;
  localparam int unsigned PhaseCnt  = 5;
  localparam int unsigned PhaseLen  = 92;
  localparam int unsigned RowCnt    = 12;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } frame_byte_t;

  // text == 0: payload comes from the predictor
  typedef struct packed {
    logic [ReadingW-1:0] one;
    logic [ReadingW-1:0] two;
    logic [TextW-1:0]    text;
  } pair_row_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                in_valid_i    = 1'b0;
  logic                in_stall_o;
  logic [ReadingW-1:0] reading_one_i = '0;
  logic [ReadingW-1:0] reading_two_i = '0;
  logic                out_valid_o;
  logic                out_stall_i   = 1'b0;
  logic [ByteW-1:0]    frame_byte_o;
  logic                last_byte_o;
  logic                psel          = 1'b0;
  logic                penable       = 1'b0;
  logic                pwrite        = 1'b0;
  logic [2:0]          paddr         = '0;
  logic [31:0]         pwdata        = '0;
  logic [31:0]         prdata;
  logic                pready;

  frame_byte_t   pending_bytes[$];
  logic [15:0]   cfg_dest   = DestReset;
  logic [15:0]   cfg_source = SourceReset;
  int unsigned   err_cnt    = 0;
  int unsigned   quiet_cnt  = 0;
  int unsigned   rx_hold_len = 0;
  bit            tx_idle_on = 1'b1;
  bit            rx_idle_on = 1'b1;
  frame_byte_t   got_byte;

  pair_row_t directed_rows [RowCnt] = '{
    '{16'd0,     16'd0,     "R1:00000,R2:00000"},
    '{16'd65535, 16'd65535, "R1:65535,R2:65535"},
    '{16'd0,     16'd65535, "R1:00000,R2:65535"},
    '{16'd65535, 16'd0,     "R1:65535,R2:00000"},
    '{16'd1,     16'd10,    "R1:00001,R2:00010"},
    '{16'd100,   16'd1000,  "R1:00100,R2:01000"},
    '{16'd10000, 16'd9,     "R1:10000,R2:00009"},
    '{16'd9999,  16'd59999, '0},
    '{16'd12345, 16'd54321, '0},
    '{16'hAAAA,  16'h5555,  '0},
    '{16'd32768, 16'd32767, '0},
    '{16'd99,    16'd999,   '0}
  };

  sensor_ascii_frame_builder i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .reading_one_i (reading_one_i),
    .reading_two_i (reading_two_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .frame_byte_o  (frame_byte_o),
    .last_byte_o   (last_byte_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #5 clk_i = ~clk_i;

  function automatic void note_error(input string msg);
    err_cnt++;
    if (err_cnt <= 10) $display("ERROR @%0t: %s", $realtime, msg);
  endfunction

  function automatic logic [39:0] ascii5(input logic [15:0] v);
    logic [39:0] s;
    int unsigned div;
    int unsigned k;
    s   = '0;
    div = 10000;
    for (k = 0; k < 5; k++) begin
      s   = {s[31:0], 8'h30 + 8'((v / div) % 10)};
      div = div / 10;
    end
    return s;
  endfunction

  // Header from the current addresses, then the 17 payload characters
  function automatic void queue_frame(input logic [ReadingW-1:0] one,
                                      input logic [ReadingW-1:0] two,
                                      input logic [TextW-1:0] text);
    logic [TextW-1:0] payload;
    int unsigned i;
    payload = (text != '0) ? text : {"R1:", ascii5(one), ",R2:", ascii5(two)};
    pending_bytes.push_back('{cfg_dest[7:0], 1'b0});
    pending_bytes.push_back('{cfg_dest[15:8], 1'b0});
    pending_bytes.push_back('{cfg_source[7:0], 1'b0});
    pending_bytes.push_back('{cfg_source[15:8], 1'b0});
    pending_bytes.push_back('{LenByte, 1'b0});
    for (i = 0; i < 17; i++)
      pending_bytes.push_back('{payload[8*(16-i) +: 8], i == 16});
  endfunction

  function automatic logic [ReadingW-1:0] random_reading();
    logic [ReadingW-1:0] v;
    case ($urandom_range(0, 5))
      0, 1: v = 16'($urandom);
      2: v = 16'($urandom_range(0, 99));
      3: begin
        case ($urandom_range(0, 5))
          0: v = 16'd9;
          1: v = 16'd99;
          2: v = 16'd999;
          3: v = 16'd9999;
          4: v = 16'd59999;
          default: v = 16'd65535;
        endcase
        v = v + 16'($urandom_range(0, 1));
      end
      4: v = 16'($urandom_range(9990, 10010));
      default: v = 16'($urandom_range(60000, 65535));
    endcase
    return v;
  endfunction

  // Leaves valid high after the transaction; the next call or drop_valid decides
  task automatic send_pair(input logic [ReadingW-1:0] one,
                           input logic [ReadingW-1:0] two,
                           input logic [TextW-1:0] text);
    int unsigned gap;
    gap = (tx_idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i    <= 1'b1;
    reading_one_i <= one;
    reading_two_i <= two;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    queue_frame(one, two, text);
  endtask

  task automatic drop_valid();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  task automatic drain();
    while (pending_bytes.size() != 0) @(posedge clk_i);
  endtask

  task automatic apb_xfer(input logic wr, input logic [2:0] addr,
                          input logic [31:0] data, output logic [31:0] rd);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    rd = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] data);
    logic [31:0] unused;
    apb_xfer(1'b1, {idx, 2'b00}, data, unused);
    if (idx == RegDest) cfg_dest = data[15:0];
    else cfg_source = data[15:0];
  endtask

  task automatic check_reg(input logic idx, input logic [15:0] want);
    logic [31:0] rd;
    apb_xfer(1'b0, {idx, 2'b00}, 32'h0, rd);
    if (rd[15:0] !== want)
      note_error($sformatf("register %0d read: expected %h, got %h", idx, want, rd[15:0]));
  endtask

  // Receiver: random stall bursts, or one long hold when requested
  initial begin : rx_stall
    int unsigned burst;
    forever begin
      @(negedge clk_i);
      if (rx_hold_len != 0) begin
        out_stall_i <= 1'b1;
        repeat (rx_hold_len - 1) @(negedge clk_i);
        rx_hold_len = 0;
      end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
        burst = $urandom_range(1, 4);
        out_stall_i <= 1'b1;
        repeat (burst - 1) @(negedge clk_i);
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Output transactions against the oldest expected byte
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (pending_bytes.size() == 0) begin
        note_error($sformatf("unexpected byte %h last %b", frame_byte_o, last_byte_o));
      end else begin
        got_byte = pending_bytes.pop_front();
        if (frame_byte_o !== got_byte.value)
          note_error($sformatf("frame_byte: expected %h, got %h", got_byte.value, frame_byte_o));
        if (last_byte_o !== got_byte.last)
          note_error($sformatf("last_byte: expected %b, got %b", got_byte.last, last_byte_o));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_stall_o === 1'b0) || (out_valid_o === 1'b1 && !out_stall_i) ||
        (psel && penable)) begin
      quiet_cnt <= 0;
    end else if (quiet_cnt >= QuietMax) begin
      $display("sensor_ascii_frame_builder test failed");
      $finish;
    end else begin
      quiet_cnt <= quiet_cnt + 1;
    end
  end

  initial begin : stimulus
    int unsigned row;
    int unsigned phase;
    int unsigned i;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    check_reg(RegDest, 16'd51);
    check_reg(RegSource, 16'd1);

    for (row = 0; row < RowCnt; row++)
      send_pair(directed_rows[row].one, directed_rows[row].two, directed_rows[row].text);

    for (phase = 0; phase < PhaseCnt; phase++) begin
      if (phase != 0) begin
        drop_valid();
        drain();
        case (phase)
          1: begin
            write_reg(RegDest, 32'h0);
            write_reg(RegSource, 32'hFFFF_FFFF);  // upper half must be dropped
          end
          2: begin
            write_reg(RegDest, 32'hA5A5_FFFF);
            write_reg(RegSource, 32'h0001_0000);
          end
          default: begin
            write_reg(RegDest, $urandom);
            write_reg(RegSource, $urandom);
          end
        endcase
        check_reg(RegDest, cfg_dest);
        check_reg(RegSource, cfg_source);
      end
      tx_idle_on = (phase != PhaseCnt - 1);
      rx_idle_on = (phase != PhaseCnt - 1);
      for (i = 0; i < PhaseLen; i++) begin
        // long receiver hold while the sender keeps pushing: fills the queue
        if (phase == 2 && i == 20) rx_hold_len = HoldLen;
        if (phase == 1 && i == 45) begin
          drop_valid();
          drain();
        end
        send_pair(random_reading(), random_reading(), '0);
      end
    end

    drop_valid();
    drain();
    repeat (TailWait) @(posedge clk_i);
    if (err_cnt == 0 && pending_bytes.size() == 0) begin
      $display("sensor_ascii_frame_builder test passed");
    end else begin
      $display("sensor_ascii_frame_builder test failed");
    end
    $finish;
  end

endmodule
